[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the text console checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TCW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Field widths, item packing, cell constants and attribute lookup for the
// text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  typedef logic [15:0] cell_t;

  // input item fields
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 3;
  localparam int RROW_W   = 5;
  localparam int RCOL_W   = 7;
  localparam int IN_CHAR_LSB  = 0;
  localparam int IN_COLOR_LSB = IN_CHAR_LSB + CHAR_W;
  localparam int IN_RROW_LSB  = IN_COLOR_LSB + COLOR_W;
  localparam int IN_RCOL_LSB  = IN_RROW_LSB + RROW_W;
  localparam int IN_FIELDS_W  = IN_RCOL_LSB + RCOL_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // result item fields
  localparam int CELL_W      = 16;
  localparam int CURCOL_W    = 7;
  localparam int CURROW_W    = 5;
  localparam int OUT_CELL_LSB = 0;
  localparam int OUT_COL_LSB  = OUT_CELL_LSB + CELL_W;
  localparam int OUT_ROW_LSB  = OUT_COL_LSB + CURCOL_W;
  localparam int OUT_FIELDS_W = OUT_ROW_LSB + CURROW_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // tuser bit positions on the result side
  localparam int UF_ACCEPTED = 0;
  localparam int UF_SCROLLED = 1;
  localparam int OUT_USER_W  = 2;

  localparam cell_t CELL_RESET = 16'h0720;
  localparam cell_t CELL_BLANK = 16'h0020;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;

  localparam logic [COLOR_W-1:0] COLOR_GRAY   = 3'd1;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd2;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd3;
  localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd4;
  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'd5;

  localparam logic [7:0] ATTR_WHITE  = 8'h0F;
  localparam logic [7:0] ATTR_GRAY   = 8'h07;
  localparam logic [7:0] ATTR_YELLOW = 8'h0E;
  localparam logic [7:0] ATTR_RED    = 8'h0C;
  localparam logic [7:0] ATTR_BLUE   = 8'h09;
  localparam logic [7:0] ATTR_GREEN  = 8'h0A;

  function automatic logic [7:0] attr_of(input logic [COLOR_W-1:0] color);
    logic [7:0] a;
    case (color)
      COLOR_GRAY:   a = ATTR_GRAY;
      COLOR_YELLOW: a = ATTR_YELLOW;
      COLOR_RED:    a = ATTR_RED;
      COLOR_BLUE:   a = ATTR_BLUE;
      COLOR_GREEN:  a = ATTR_GREEN;
      default:      a = ATTR_WHITE;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[design/tcw_mem.sv]
// ----------------------------------------------------------------------------
// tcw_mem
// Single-port screen store, one write or one read per cycle, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire              clk,
  input  wire              we,
  input  wire [AW-1:0]     addr,
  input  tcw_pkg::cell_t   wdata,
  output tcw_pkg::cell_t   rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text console over a ROWS x COLUMNS screen store with cursor, wrap and
// scroll handling.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel: tuser selects write (0) or read (1),
// tdata carries the character, colour and read position. Each item gives
// exactly one result item on the m_ channel (cell, cursor, flags).
// cfg_wr_en/cfg_wr_data set the console enable; write it only while idle.
// The screen lives in one single-port memory. Rows are kept as a ring with
// a base row register, so a scroll moves no data: it advances the base and
// blanks the row that becomes the bottom one, one cell per cycle.
// Steps per item: a disabled write, newline or tab, or an out-of-range
// read goes straight to S_OUT; a character write passes S_WRITE; a read
// passes S_READ and S_RDATA; a write that scrolls first blanks the row in
// S_WALK. Each memory access takes its own state on the single port.
// After reset the store is filled with CELL_RESET cells while s_tready is
// low. The finished result is held in an output register;
// while m_tready is low the block finishes the item in hand and then waits
// with s_tready low until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire                               cfg_wr_data,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // char_code[7:0], color[10:8], read_row[15:11], read_col[22:16]
  input  wire  [tcw_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode[0]
  input  wire  [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // cell_value[15:0], cursor_col[22:16], cursor_row[27:23]
  output logic [tcw_pkg::OUT_DATA_W-1:0]    m_tdata,
  // accepted[0], scrolled[1]
  output logic [tcw_pkg::OUT_USER_W-1:0]    m_tuser
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int PW    = $clog2(ROWS);
  localparam int KW    = $clog2(COLUMNS);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_RDATA = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic                tty_en;
  logic [CW-1:0]       cur_col;
  logic [RW-1:0]       cur_row;
  logic [PW-1:0]       base;
  logic [AW-1:0]       clr_addr;
  logic [KW-1:0]       walk;
  logic [PW-1:0]       op_prow;
  logic [KW-1:0]       op_col;
  tcw_pkg::cell_t      op_cell;
  tcw_pkg::cell_t      res_cell;
  logic                res_acc;
  logic                res_scr;

  tcw_pkg::cell_t      out_cell;
  logic [CW-1:0]       out_col;
  logic [RW-1:0]       out_row;
  logic                out_acc;
  logic                out_scr;
  logic                out_load;

  // item fields
  logic                          in_mode;
  logic [tcw_pkg::CHAR_W-1:0]    in_char;
  logic [tcw_pkg::COLOR_W-1:0]   in_color;
  logic [tcw_pkg::RROW_W-1:0]    in_rrow;
  logic [tcw_pkg::RCOL_W-1:0]    in_rcol;

  assign in_mode  = s_tuser[0];
  assign in_char  = s_tdata[tcw_pkg::IN_CHAR_LSB  +: tcw_pkg::CHAR_W];
  assign in_color = s_tdata[tcw_pkg::IN_COLOR_LSB +: tcw_pkg::COLOR_W];
  assign in_rrow  = s_tdata[tcw_pkg::IN_RROW_LSB  +: tcw_pkg::RROW_W];
  assign in_rcol  = s_tdata[tcw_pkg::IN_RCOL_LSB  +: tcw_pkg::RCOL_W];

  // cursor arithmetic for a write item
  logic          wrap;
  logic [CW-1:0] col_w;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] line_w;
  logic          scroll;
  logic [RW-1:0] line_f;
  logic [CW:0]   tab_sum;
  logic [CW-1:0] tab_col;
  logic [PW-1:0] base_inc;
  logic          rd_in_range;

  always_comb begin
    wrap     = cur_col >= CW'(COLUMNS);
    col_w    = wrap ? '0 : cur_col;
    row_inc  = (cur_row < RW'(ROWS)) ? cur_row + RW'(1) : cur_row;
    line_w   = wrap ? row_inc : cur_row;
    scroll   = line_w >= RW'(ROWS);
    line_f   = scroll ? RW'(ROWS - 1) : line_w;
    tab_sum  = {1'b0, cur_col} + (CW+1)'(TAB_STEP);
    tab_col  = (tab_sum > (CW+1)'(COLUMNS)) ? CW'(COLUMNS) : tab_sum[CW-1:0];
    base_inc = (base == PW'(ROWS - 1)) ? '0 : base + PW'(1);
    rd_in_range = (int'(in_rrow) < ROWS) && (int'(in_rcol) < COLUMNS);
  end

  // logical to physical row through the ring base
  logic [PW-1:0] map_in;
  logic [PW:0]   map_sum;
  logic [PW-1:0] map_out;

  always_comb begin
    map_in  = in_mode ? PW'(in_rrow) : PW'(line_f);
    map_sum = {1'b0, map_in} + {1'b0, base};
    if (map_sum >= (PW+1)'(ROWS)) begin
      map_out = PW'(map_sum - (PW+1)'(ROWS));
    end else begin
      map_out = PW'(map_sum);
    end
  end

  // memory port
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  tcw_pkg::cell_t mem_wdata;
  tcw_pkg::cell_t mem_rdata;
  logic [KW-1:0]  addr_col;
  logic [AW-1:0]  row_addr;

  always_comb begin
    addr_col  = (state == S_WALK) ? walk : op_col;
    row_addr  = AW'(op_prow) * AW'(COLUMNS) + AW'(addr_col);
    mem_we    = 1'b0;
    mem_addr  = row_addr;
    mem_wdata = op_cell;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = tcw_pkg::CELL_RESET;
      end
      S_WALK: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::CELL_BLANK;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  tcw_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      tty_en   <= 1'b1;
      cur_col  <= '0;
      cur_row  <= '0;
      base     <= '0;
      clr_addr <= '0;
      walk     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tty_en <= cfg_wr_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op_cell <= {tcw_pkg::attr_of(in_color), in_char};
            if (in_mode) begin
              res_cell <= '0;
              res_scr  <= 1'b0;
              res_acc  <= rd_in_range;
              op_prow  <= map_out;
              op_col   <= KW'(in_rcol);
              if (rd_in_range) begin
                state <= S_READ;
              end else begin
                state <= S_OUT;
              end
            end else if (!tty_en) begin
              res_cell <= '0;
              res_acc  <= 1'b0;
              res_scr  <= 1'b0;
              state    <= S_OUT;
            end else if (in_char == tcw_pkg::CH_NEWLINE) begin
              res_cell <= '0;
              res_acc  <= 1'b1;
              res_scr  <= 1'b0;
              cur_row  <= row_inc;
              cur_col  <= '0;
              state    <= S_OUT;
            end else if (in_char == tcw_pkg::CH_TAB) begin
              res_cell <= '0;
              res_acc  <= 1'b1;
              res_scr  <= 1'b0;
              cur_col  <= tab_col;
              state    <= S_OUT;
            end else begin
              res_acc  <= 1'b1;
              res_scr  <= scroll;
              res_cell <= {tcw_pkg::attr_of(in_color), in_char};
              op_col   <= KW'(col_w);
              cur_col  <= col_w + CW'(1);
              cur_row  <= line_f;
              if (scroll) begin
                // the old top row becomes the bottom row of the new ring
                op_prow <= base;
                base    <= base_inc;
                walk    <= '0;
                state   <= S_WALK;
              end else begin
                op_prow <= map_out;
                state   <= S_WRITE;
              end
            end
          end
        end
        S_READ: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          res_cell <= mem_rdata;
          state    <= S_OUT;
        end
        S_WALK: begin
          walk <= walk + KW'(1);
          if (walk == KW'(COLUMNS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_cell <= res_cell;
            out_col  <= cur_col;
            out_row  <= cur_row;
            out_acc  <= res_acc;
            out_scr  <= res_scr;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    m_tdata = {{tcw_pkg::OUT_PAD_W{1'b0}},
               tcw_pkg::CURROW_W'(out_row),
               tcw_pkg::CURCOL_W'(out_col),
               out_cell};
    m_tuser = '0;
    m_tuser[tcw_pkg::UF_ACCEPTED] = out_acc;
    m_tuser[tcw_pkg::UF_SCROLLED] = out_scr;
  end

endmodule

`default_nettype wire

[design/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the result channel of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire                             clk,
  input wire                             rst,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [tcw_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire [tcw_pkg::OUT_USER_W-1:0]   m_tuser
);

  logic [tcw_pkg::CURCOL_W-1:0] chk_col;
  logic [tcw_pkg::CURROW_W-1:0] chk_row;
  logic                         chk_acc;
  logic                         chk_scr;

  assign chk_col = m_tdata[tcw_pkg::OUT_COL_LSB +: tcw_pkg::CURCOL_W];
  assign chk_row = m_tdata[tcw_pkg::OUT_ROW_LSB +: tcw_pkg::CURROW_W];
  assign chk_acc = m_tuser[tcw_pkg::UF_ACCEPTED];
  assign chk_scr = m_tuser[tcw_pkg::UF_SCROLLED];

  // a stalled result holds
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // a scroll only comes from a write that was carried out
  `TCW_ASSERT_IMPL(a_scr_acc, clk, rst, m_tvalid && chk_scr, chk_acc, "scroll without accepted write")

  // after a scroll the cursor sits on the bottom row
  `TCW_ASSERT_IMPL(a_scr_row, clk, rst, m_tvalid && chk_scr, chk_row == tcw_pkg::CURROW_W'(ROWS - 1), "scroll left cursor off bottom row")

  // cursor column never passes the wrap position
  `TCW_ASSERT_IMPL(a_col_rng, clk, rst, m_tvalid, int'(chk_col) <= COLUMNS, "cursor column out of range")

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[dv/text_console_writer_tb.sv]
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A directed table covers
// reads at two screen corners and out of range, every colour, newline, tab,
// column and row saturation, the scroll and the disabled console; random
// items follow over several enable settings. Each result item is checked
// against a typed table entry or the in-bench screen, cursor and enable model.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_tb;

  localparam int N_COLS    = 80;
  localparam int N_ROWS    = 25;
  localparam int TAB_WIDTH = 4;
  localparam int LIMIT     = 600000;

  typedef enum bit {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic [tcw_pkg::CHAR_W-1:0]  ch;
    logic [tcw_pkg::COLOR_W-1:0] colour;
    logic [tcw_pkg::RROW_W-1:0]  rrow;
    logic [tcw_pkg::RCOL_W-1:0]  rcol;
  } console_item_t;

  typedef struct packed {
    tcw_pkg::cell_t               cell_value;
    logic [tcw_pkg::CURCOL_W-1:0] col;
    logic [tcw_pkg::CURROW_W-1:0] row;
    logic                         accepted;
    logic                         scrolled;
  } console_result_t;

  typedef struct {
    bit              en;
    console_item_t   item;
    int              reps;
    bit              typed;
    console_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tcw_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [tcw_pkg::OUT_USER_W-1:0] m_tuser;

  // model state
  tcw_pkg::cell_t screen_image [N_ROWS][N_COLS];
  int cur_col;
  int cur_row;
  bit tty_en;
  logic [7:0] colour_attr [8] = '{tcw_pkg::ATTR_WHITE, tcw_pkg::ATTR_GRAY,
                                  tcw_pkg::ATTR_YELLOW, tcw_pkg::ATTR_RED,
                                  tcw_pkg::ATTR_BLUE, tcw_pkg::ATTR_GREEN,
                                  tcw_pkg::ATTR_WHITE, tcw_pkg::ATTR_WHITE};

  console_result_t pending_results [$];
  stim_row_t directed [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int rx_wait = 0;
  bit rx_burst = 1'b0;
  bit tx_burst = 1'b0;
  int unsigned cycles = 0;

  text_console_writer #(
    .COLUMNS (N_COLS),
    .ROWS    (N_ROWS),
    .TAB_STEP(TAB_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL text_console_writer");
      $finish;
    end
  end

  function automatic console_result_t console_predict(console_item_t it);
    console_result_t r;
    int rr;
    int cc;
    r = '0;
    if (it.op == OP_READ) begin
      if (it.rrow < N_ROWS && it.rcol < N_COLS) begin
        r.cell_value = screen_image[it.rrow][it.rcol];
        r.accepted = 1'b1;
      end
    end else if (tty_en) begin
      r.accepted = 1'b1;
      if (it.ch == tcw_pkg::CH_NEWLINE) begin
        if (cur_row < N_ROWS) cur_row++;
        cur_col = 0;
      end else if (it.ch == tcw_pkg::CH_TAB) begin
        cur_col = (cur_col + TAB_WIDTH > N_COLS) ? N_COLS : cur_col + TAB_WIDTH;
      end else begin
        if (cur_col >= N_COLS) begin
          cur_col = 0;
          if (cur_row < N_ROWS) cur_row++;
        end
        if (cur_row >= N_ROWS) begin
          // scroll: shift every row up, blank the bottom one
          cur_row = N_ROWS - 1;
          for (rr = 0; rr < N_ROWS - 1; rr++) screen_image[rr] = screen_image[rr + 1];
          for (cc = 0; cc < N_COLS; cc++) screen_image[N_ROWS - 1][cc] = tcw_pkg::CELL_BLANK;
          r.scrolled = 1'b1;
        end
        r.cell_value = {colour_attr[it.colour], it.ch};
        screen_image[cur_row][cur_col] = r.cell_value;
        cur_col++;
      end
    end
    r.col = cur_col[tcw_pkg::CURCOL_W-1:0];
    r.row = cur_row[tcw_pkg::CURROW_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // result side: random stalls, check against the oldest expectation
  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.cell_value = m_tdata[tcw_pkg::OUT_CELL_LSB +: tcw_pkg::CELL_W];
        got.col        = m_tdata[tcw_pkg::OUT_COL_LSB +: tcw_pkg::CURCOL_W];
        got.row        = m_tdata[tcw_pkg::OUT_ROW_LSB +: tcw_pkg::CURROW_W];
        got.accepted   = m_tuser[tcw_pkg::UF_ACCEPTED];
        got.scrolled   = m_tuser[tcw_pkg::UF_SCROLLED];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item, cell", got.cell_value, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.cell_value !== want.cell_value)
            report_mismatch("cell_value", got.cell_value, want.cell_value);
          if (got.col !== want.col) report_mismatch("cursor_col", got.col, want.col);
          if (got.row !== want.row) report_mismatch("cursor_row", got.row, want.row);
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
          if (got.scrolled !== want.scrolled)
            report_mismatch("scrolled", got.scrolled, want.scrolled);
        end
        results_seen++;
        if (results_seen % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  task automatic send_item(console_item_t it, bit typed, console_result_t want);
    logic [tcw_pkg::IN_DATA_W-1:0] word;
    int gap;
    console_result_t predicted;
    if (items_sent % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    word = '0;
    word[tcw_pkg::IN_CHAR_LSB +: tcw_pkg::CHAR_W]   = it.ch;
    word[tcw_pkg::IN_COLOR_LSB +: tcw_pkg::COLOR_W] = it.colour;
    word[tcw_pkg::IN_RROW_LSB +: tcw_pkg::RROW_W]   = it.rrow;
    word[tcw_pkg::IN_RCOL_LSB +: tcw_pkg::RCOL_W]   = it.rcol;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= it.op;
    do @(posedge clk); while (!s_tready);
    predicted = console_predict(it);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // drain, then write the enable while the block is idle
  task automatic set_console_enable(bit en);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tty_en = en;
  endtask

  task automatic add_row(bit en, op_e op, logic [7:0] ch, logic [2:0] colour,
                         logic [4:0] rrow, logic [6:0] rcol, int reps,
                         bit typed, console_result_t want);
    stim_row_t row;
    row.en = en;
    row.item = '{op: op, ch: ch, colour: colour, rrow: rrow, rcol: rcol};
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    directed.push_back(row);
  endtask

  initial begin : stimulus
    console_result_t none;
    console_result_t blank_read;
    console_result_t refused;
    console_item_t it;
    int ph;
    int n;
    int sel;
    int k;
    none = '0;
    blank_read = '{cell_value: tcw_pkg::CELL_RESET, col: 0, row: 0, accepted: 1'b1,
                   scrolled: 1'b0};
    refused = '0;
    for (k = 0; k < N_ROWS * N_COLS; k++)
      screen_image[k / N_COLS][k % N_COLS] = tcw_pkg::CELL_RESET;
    cur_col = 0;
    cur_row = 0;
    tty_en = 1'b1;

    // en, op, char, colour, read row, read col, repeats, typed, expected
    add_row(1, OP_READ,  8'h00, 3'd0, 5'd0,  7'd0,   1, 1, blank_read);
    add_row(1, OP_READ,  8'h00, 3'd0, 5'd24, 7'd79,  1, 1, blank_read);
    add_row(1, OP_READ,  8'h00, 3'd0, 5'd25, 7'd0,   1, 1, refused);
    add_row(1, OP_READ,  8'h00, 3'd0, 5'd0,  7'd80,  1, 1, refused);
    add_row(1, OP_READ,  8'hFF, 3'd7, 5'd31, 7'd127, 1, 1, refused);
    add_row(1, OP_WRITE, 8'h00, 3'd0, 5'd0,  7'd0,   1, 1,
            '{cell_value: 16'h0F00, col: 1, row: 0, accepted: 1'b1, scrolled: 1'b0});
    add_row(1, OP_WRITE, 8'hFF, 3'd7, 5'd31, 7'd127, 1, 1,
            '{cell_value: 16'h0FFF, col: 2, row: 0, accepted: 1'b1, scrolled: 1'b0});
    add_row(1, OP_WRITE, "A", tcw_pkg::COLOR_GRAY,   5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, "B", tcw_pkg::COLOR_YELLOW, 5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, "C", tcw_pkg::COLOR_RED,    5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, "D", tcw_pkg::COLOR_BLUE,   5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, "E", tcw_pkg::COLOR_GREEN,  5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, "F", 3'd6,                  5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, tcw_pkg::CH_TAB,     3'd0, 5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, tcw_pkg::CH_NEWLINE, 3'd0, 5'd0, 7'd0, 1, 0, none);
    // tabs run past the last column and pin it there
    add_row(1, OP_WRITE, tcw_pkg::CH_TAB,     3'd0, 5'd0, 7'd0, 25, 0, none);
    add_row(1, OP_WRITE, "w", tcw_pkg::COLOR_YELLOW, 5'd0, 7'd0, 1, 0, none);
    // newlines past the bottom row saturate it
    add_row(1, OP_WRITE, tcw_pkg::CH_NEWLINE, 3'd0, 5'd0, 7'd0, 30, 0, none);
    add_row(1, OP_WRITE, "s", tcw_pkg::COLOR_RED, 5'd0, 7'd0, 1, 0, none);
    add_row(1, OP_READ,  8'h00, 3'd0, 5'd24, 7'd0, 1, 0, none);
    add_row(1, OP_READ,  8'h00, 3'd0, 5'd23, 7'd0, 1, 0, none);
    add_row(1, OP_READ,  8'h00, 3'd0, 5'd0,  7'd1, 1, 0, none);
    // console disabled: writes refused, reads still served
    add_row(0, OP_WRITE, "d", tcw_pkg::COLOR_GREEN, 5'd0, 7'd0, 1, 0, none);
    add_row(0, OP_WRITE, tcw_pkg::CH_NEWLINE, 3'd0, 5'd0, 7'd0, 1, 0, none);
    add_row(0, OP_WRITE, tcw_pkg::CH_TAB,     3'd0, 5'd0, 7'd0, 1, 0, none);
    add_row(0, OP_READ,  8'h00, 3'd0, 5'd24, 7'd0, 1, 0, none);
    add_row(1, OP_WRITE, "e", tcw_pkg::COLOR_BLUE, 5'd0, 7'd0, 1, 0, none);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_console_enable(1'b1);

    foreach (directed[i]) begin
      if (directed[i].en != tty_en) set_console_enable(directed[i].en);
      repeat (directed[i].reps) send_item(directed[i].item, directed[i].typed, directed[i].want);
    end

    for (ph = 0; ph < 4; ph++) begin
      set_console_enable(ph != 1);
      n = (ph == 1) ? 60 : 300;
      for (k = 0; k < n; k++) begin
        it.op = ($urandom_range(0, 99) < 30) ? OP_READ : OP_WRITE;
        sel = $urandom_range(0, 99);
        it.ch = (sel < 15) ? tcw_pkg::CH_NEWLINE :
                (sel < 22) ? tcw_pkg::CH_TAB : 8'($urandom_range(0, 255));
        it.colour = tcw_pkg::COLOR_W'($urandom_range(0, 7));
        it.rrow = tcw_pkg::RROW_W'($urandom_range(0, 31));
        it.rcol = tcw_pkg::RCOL_W'($urandom_range(0, 127));
        if (it.op == OP_READ) begin
          sel = $urandom_range(0, 99);
          // mostly in range, often on the line being written
          if (sel < 40) it.rrow = tcw_pkg::RROW_W'((cur_row < N_ROWS) ? cur_row : N_ROWS - 1);
          else if (sel < 90) it.rrow = tcw_pkg::RROW_W'($urandom_range(0, N_ROWS - 1));
          if ($urandom_range(0, 9) != 0)
            it.rcol = tcw_pkg::RCOL_W'($urandom_range(0, N_COLS - 1));
        end
        send_item(it, 1'b0, none);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * N_COLS) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

endmodule

`default_nettype wire
